// ----- rtl/core/lkvc_pkg.sv -----
// Shared types, constants and state codes for the LRU key-value cache.
package lkvc_pkg;

	// Number of cells in the recency chain
	localparam int unsigned ENTRIES = 16;

	localparam int unsigned KEY_W   = 16;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CAP_W   = 5;
	localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
	// Width that holds both the capacity register and the fill count
	localparam int unsigned CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Register indexes and operation codes
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic OP_GET       = 1'b0;
	localparam logic OP_PUT       = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// One stored entry as it moves along the chain
	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} lkvc_entry_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp;       // capture key match
		logic upd;       // apply the shift for this item
		logic miss_put;  // put whose key is absent
		logic evict;     // drop the least recent entry
	} lkvc_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} lkvc_state_t;

endpackage

// ----- rtl/core/lkvc_cell.sv -----
// One cell of the recency chain: holds a single entry, most recent at the head.
module lkvc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkvc_pkg::lkvc_ctl_t         ctl,
	input  logic [lkvc_pkg::KEY_W-1:0]  in_key,
	input  lkvc_pkg::lkvc_entry_t       prev,
	output lkvc_pkg::lkvc_entry_t       cur,
	input  logic                        tail_in,
	output logic                        tail_out,
	input  logic [lkvc_pkg::VALUE_W-1:0] hv_in,
	output logic [lkvc_pkg::VALUE_W-1:0] hv_out
);

	logic                          valid_q;
	logic [lkvc_pkg::KEY_W-1:0]    key_q;
	logic [lkvc_pkg::VALUE_W-1:0]  value_q;
	logic                          match_q;
	logic                          shift;

	// match here or further down the chain: this cell moves on a hit
	assign tail_out = match_q | tail_in;
	assign hv_out   = hv_in | (match_q ? value_q : '0);
	assign cur      = '{valid: valid_q, key: key_q, value: value_q};

	// on an insert with eviction every valid cell takes its neighbour and the
	// last one's entry falls off; without eviction the first free cell fills too
	always_comb begin
		shift = ctl.upd & (tail_out | (ctl.miss_put & (ctl.evict ? valid_q : prev.valid)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp)
				match_q <= valid_q && (key_q == in_key);
			if (shift)
				valid_q <= prev.valid;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

endmodule

// ----- rtl/core/lru_key_value_cache_unit.sv -----
// Top level of the LRU key-value cache: sequencer, cell chain and config port.
//
//  channel   | direction | signals                          | contents
//  ----------+-----------+----------------------------------+-------------------------------
//  s_axis    | in        | tvalid tready tdata[47:0] tuser  | tdata: key, value; tuser: op
//  m_axis    | out       | tvalid tready tdata[31:0] tuser  | tdata: read_value; tuser: hit, evicted
//  apb       | in/out    | psel penable pwrite paddr pwdata | capacity at address 0
//
// Each item goes through accept, key compare in every cell, then the
// chain shift and result write. The shift waits while the output register
// is full and not being taken; the next item is accepted meanwhile only once
// the shift is done. Reset clears all valid marks and the fill count at once,
// no clearing pass.
module lru_key_value_cache_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [15:0] key, [47:16] value
	input  logic        s_axis_tuser,   // [0] operation
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] read_value
	output logic [1:0]  m_axis_tuser,   // [0] hit, [1] evicted
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned N = lkvc_pkg::ENTRIES;

	lkvc_pkg::lkvc_state_t state_q, state_d;

	logic [lkvc_pkg::CAP_W-1:0]   cap_q;
	logic [lkvc_pkg::CNT_W-1:0]   occ_q;
	logic                         op_q;
	logic [lkvc_pkg::KEY_W-1:0]   key_q;
	logic [lkvc_pkg::VALUE_W-1:0] val_q;

	logic                         out_valid_q;
	logic [lkvc_pkg::VALUE_W-1:0] out_data_q;
	logic                         out_hit_q;
	logic                         out_evict_q;

	lkvc_pkg::lkvc_ctl_t          ctl;
	lkvc_pkg::lkvc_entry_t        chain [N+1];
	logic                         tail  [N+1];
	logic [lkvc_pkg::VALUE_W-1:0] hv    [N+1];

	logic                         accept;
	logic                         upd_go;
	logic                         hit;
	logic [lkvc_pkg::CMP_W-1:0]   cap_ext;
	logic [lkvc_pkg::CMP_W-1:0]   eff_cap;
	logic                         cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00)
		&& (paddr[2] == lkvc_pkg::REG_CAPACITY);
	assign prdata = (paddr == 3'b000) ? 32'(cap_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= lkvc_pkg::CAP_RESET;
		else if (cfg_wr)
			cap_q <= pwdata[lkvc_pkg::CAP_W-1:0];
	end

	// effective capacity: zero acts as one, clipped to the chain length
	always_comb begin
		cap_ext = lkvc_pkg::CMP_W'(cap_q);
		if (cap_ext == '0)
			eff_cap = lkvc_pkg::CMP_W'(1);
		else if (cap_ext > lkvc_pkg::CMP_W'(N))
			eff_cap = lkvc_pkg::CMP_W'(N);
		else
			eff_cap = cap_ext;
	end

	// sequencer
	assign accept = s_axis_tvalid && s_axis_tready;
	assign upd_go = (state_q == lkvc_pkg::ST_UPD) && (!out_valid_q || m_axis_tready);
	assign hit    = tail[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lkvc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ctl           = '0;
		case (state_q)
			lkvc_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = lkvc_pkg::ST_CMP;
			end
			lkvc_pkg::ST_CMP: begin
				ctl.cmp = 1'b1;
				state_d = lkvc_pkg::ST_UPD;
			end
			lkvc_pkg::ST_UPD: begin
				ctl.upd      = upd_go;
				ctl.miss_put = !hit && (op_q == lkvc_pkg::OP_PUT);
				ctl.evict    = ctl.miss_put && (lkvc_pkg::CMP_W'(occ_q) >= eff_cap);
				if (upd_go)
					state_d = lkvc_pkg::ST_IDLE;
			end
			default: state_d = lkvc_pkg::ST_IDLE;
		endcase
	end

	// item register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_axis_tuser;
			key_q <= s_axis_tdata[15:0];
			val_q <= s_axis_tdata[47:16];
		end
	end

	// fill count grows on an insert that evicts nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else if (ctl.upd && ctl.miss_put && !ctl.evict)
			occ_q <= occ_q + lkvc_pkg::CNT_W'(1);
	end

	// head of the chain: the entry that becomes most recent
	assign chain[0] = '{valid: 1'b1, key: key_q,
		value: (op_q == lkvc_pkg::OP_PUT) ? val_q : hv[0]};
	assign tail[N]  = 1'b0;
	assign hv[N]    = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		lkvc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.in_key   (key_q),
			.prev     (chain[i]),
			.cur      (chain[i+1]),
			.tail_in  (tail[i+1]),
			.tail_out (tail[i]),
			.hv_in    (hv[i+1]),
			.hv_out   (hv[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (upd_go)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_hit_q   <= hit;
			out_evict_q <= ctl.evict;
			out_data_q  <= (hit && (op_q == lkvc_pkg::OP_GET)) ? hv[0] : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = {out_evict_q, out_hit_q};

endmodule

// ----- rtl/core/lkvc_checker.sv -----
// Port-level checks for the LRU key-value cache, bound to the top level.
module lkvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        psel,
	input logic        pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// eviction only happens on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
		else $error("eviction reported on a hit");

	// a miss reads as zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
		else $error("nonzero read value on a miss");

	// one item in flight: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while another is in flight");

	// the config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);

// ----- tb/lru_key_value_cache_unit_tb.sv -----
// Self-checking testbench for the LRU key-value cache: directed and random gets and puts.
module lru_key_value_cache_unit_tb;
	import lkvc_pkg::*;

	localparam logic [2:0] CAP_ADDR   = 3'(4 * REG_CAPACITY);
	localparam int         QUIET_MAX  = 2000;
	localparam int         HOLD_LEN   = 120;

	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] read_value;
		logic               evicted;
	} cache_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // [15:0] key, [47:16] value
	logic        s_axis_tuser;   // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] read_value
	logic [1:0]  m_axis_tuser;   // [0] hit, [1] evicted
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lru_key_value_cache_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Shadow copy of the cache contents and recency order
	logic [KEY_W-1:0]   lru_keys   [ENTRIES];
	logic [VALUE_W-1:0] lru_values [ENTRIES];
	bit                 lru_live   [ENTRIES];
	int unsigned        lru_age    [ENTRIES];
	int unsigned        lru_fill;
	logic [CAP_W-1:0]   lru_capacity;

	cache_result_t pending_results [$];
	cache_result_t observed;
	cache_result_t wanted;

	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  hits_seen;
	int  evictions_seen;
	int  settings_used;
	int  hold_request;
	bit  src_idle;
	bit  sink_idle;
	logic [KEY_W-1:0] key_base;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Capacity as the cache applies it: zero acts as one, large values saturate
	function automatic int unsigned capacity_in_use();
		if (lru_capacity == 0)
			return 1;
		if (lru_capacity > ENTRIES)
			return ENTRIES;
		return lru_capacity;
	endfunction

	// Apply one get or put to the shadow cache and return the result it gives
	function automatic cache_result_t lru_access(input logic op, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] val);
		cache_result_t res;
		int            found;
		int            slot;
		int unsigned   oldest;
		res    = '0;
		found  = -1;
		slot   = -1;
		oldest = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && lru_live[i] && lru_keys[i] == key)
				found = i;
		if (found >= 0) begin
			// present key: read or overwrite, then promote to most recent
			res.hit = 1'b1;
			if (op == OP_GET)
				res.read_value = lru_values[found];
			else
				lru_values[found] = val;
			for (int i = 0; i < ENTRIES; i++)
				if (lru_live[i] && i != found && lru_age[i] < lru_age[found])
					lru_age[i]++;
			lru_age[found] = 0;
		end else if (op == OP_PUT) begin
			// full: drop the least recent entry and reuse its slot
			if (lru_fill + 1 > capacity_in_use()) begin
				for (int i = 0; i < ENTRIES; i++)
					if (lru_live[i] && (slot < 0 || lru_age[i] > oldest)) begin
						slot   = i;
						oldest = lru_age[i];
					end
				if (slot >= 0) begin
					lru_live[slot] = 1'b0;
					lru_fill--;
					res.evicted = 1'b1;
				end
			end
			// otherwise the lowest free slot
			if (slot < 0)
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && !lru_live[i])
						slot = i;
			if (slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++)
					if (lru_live[i])
						lru_age[i]++;
				lru_keys[slot]   = key;
				lru_values[slot] = val;
				lru_live[slot]   = 1'b1;
				lru_age[slot]    = 0;
				lru_fill++;
			end
		end
		return res;
	endfunction

	// Offer one item, wait for it to be taken, then record what should come back
	task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] val);
		if (src_idle && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {val, key};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(lru_access(op, key, val));
		items_sent++;
	endtask

	// Random get or put on a pool of 2 * capacity + 2 keys, now and then a fully random key
	task automatic send_random_op();
		logic [KEY_W-1:0] key;
		int               span;
		span = 2 * capacity_in_use() + 1;
		if ($urandom_range(0, 19) == 0)
			key = KEY_W'($urandom);
		else
			key = key_base ^ KEY_W'($urandom_range(0, span));
		send_item($urandom_range(0, 1) ? OP_PUT : OP_GET, key, $urandom);
	endtask

	// Stop offering and wait until every result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB transfer to the capacity register, with psel dropped afterwards
	task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CAP_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_capacity_reg(input logic [CAP_W-1:0] cap);
		logic [31:0] rd;
		apb_cycle(1'b0, 32'h0, rd);
		if (rd !== 32'(cap)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("capacity readback: expected %0d, got %0d", cap, rd);
		end
	endtask

	// Write the capacity with junk in the unused upper bits, then read it back
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		logic [31:0] rd;
		apb_cycle(1'b1, ($urandom & ~32'h1F) | 32'(cap), rd);
		lru_capacity = cap;
		settings_used++;
		check_capacity_reg(cap);
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			observed = '{hit: m_axis_tuser[0], read_value: m_axis_tdata,
				evicted: m_axis_tuser[1]};
			results_seen++;
			if (observed.hit === 1'b1)
				hits_seen++;
			if (observed.evicted === 1'b1)
				evictions_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with no item outstanding: hit=%0b value=%h evicted=%0b",
						results_seen, observed.hit, observed.read_value, observed.evicted);
			end else begin
				wanted = pending_results.pop_front();
				if (observed !== wanted) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d: expected hit=%0b value=%h evicted=%0b, ",
							"got hit=%0b value=%h evicted=%0b"}, results_seen,
							wanted.hit, wanted.read_value, wanted.evicted,
							observed.hit, observed.read_value, observed.evicted);
				end
			end
		end
	end

	// Output side: random stalls, plus the long hold when asked
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
				m_axis_tready <= 1'b1;
			end else if (sink_idle && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any item moving or any APB access ends the run
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_MAX) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: %0d cycles without progress, %0d results outstanding",
			QUIET_MAX, pending_results.size());
		$display("lru_key_value_cache_unit regression: fail");
		$finish;
	end

	// Reset value of the register, then basic gets and puts at full capacity
	task automatic test_basic_ops();
		check_capacity_reg(CAP_RESET);
		send_item(OP_GET, 16'h0000, 32'h0000_0000);  // miss on an empty cache
		send_item(OP_PUT, 16'h0000, 32'h0000_0000);
		send_item(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(OP_GET, 16'h0000, 32'hFFFF_FFFF);  // value ignored on a get
		send_item(OP_GET, 16'hFFFF, 32'h0000_0000);
		send_item(OP_PUT, 16'hFFFF, 32'h5A5A_A5A5);  // update in place
		send_item(OP_GET, 16'hFFFF, 32'h0000_0000);
		send_item(OP_GET, 16'h1234, 32'hFFFF_FFFF);
		drain();
	endtask

	// Capacity below occupancy, zero capacity and capacity above the entry count
	task automatic test_capacity_limits();
		set_capacity(5'd2);
		send_item(OP_PUT, 16'h0001, 32'h1111_0001);  // drops key 0
		send_item(OP_GET, 16'h0000, 32'h0);
		send_item(OP_GET, 16'hFFFF, 32'h0);
		drain();
		// zero acts as one; occupancy stays at two while inserts continue
		set_capacity(5'd0);
		send_item(OP_PUT, 16'h0002, 32'h2222_0002);
		send_item(OP_GET, 16'h0001, 32'h0);
		send_item(OP_PUT, 16'h0003, 32'h3333_0003);
		send_item(OP_GET, 16'h0002, 32'h0);
		send_item(OP_PUT, 16'h0003, 32'h3333_3333);
		drain();
		set_capacity(5'd31);
		send_item(OP_PUT, 16'h0004, 32'h4444_0004);
		send_item(OP_PUT, 16'h0005, 32'h5555_0005);
		send_item(OP_GET, 16'h0003, 32'h0);
		drain();
	endtask

	// Random traffic over a range of capacity settings, state carried across
	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps [12];
		caps = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd17, 5'd8, 5'd4, 5'd16, 5'd3, 5'd12, 5'd1};
		for (int p = 0; p < 12; p++) begin
			set_capacity(caps[p]);
			src_idle  = 1'b1;
			sink_idle = (p % 3 != 2);
			key_base  = KEY_W'($urandom);
			repeat (75) send_random_op();
			drain();
		end
	endtask

	// Long output stall while items keep coming, so the input backs up
	task automatic test_output_hold();
		set_capacity(5'd6);
		src_idle     = 1'b0;
		sink_idle    = 1'b0;
		key_base     = KEY_W'($urandom);
		hold_request = HOLD_LEN;
		@(posedge clk);
		repeat (40) send_random_op();
		drain();
	endtask

	// Full-rate traffic with no idling on either side
	task automatic test_full_rate();
		set_capacity(5'd5);
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		key_base  = KEY_W'($urandom);
		repeat (100) send_random_op();
		drain();
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		for (int i = 0; i < ENTRIES; i++) begin
			lru_live[i] = 1'b0;
			lru_age[i]  = 0;
		end
		lru_fill     = 0;
		lru_capacity = CAP_RESET;
		hold_request = 0;
		src_idle     = 1'b1;
		sink_idle    = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_capacity_limits();
		test_random_traffic();
		test_output_hold();
		test_full_rate();

		$display("%0d items, %0d results (%0d hits, %0d evictions), %0d capacity writes",
			items_sent, results_seen, hits_seen, evictions_seen, settings_used);
		$display("idle bursts on both sides, a %0d-cycle output hold and a full-rate stretch",
			HOLD_LEN);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("lru_key_value_cache_unit regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
			$display("lru_key_value_cache_unit regression: fail");
		end
		$finish;
	end

endmodule
